// ===== design/ssob_pkg.sv =====
// Shared types, widths and helpers for the shape-size-orientation barrier metric block.
package ssob_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ENT_W     = 32;
   localparam int DQ_W      = ENT_W + 1;
   localparam int MAG_W     = 32;
   localparam int PROD_W    = 2 * ENT_W;
   localparam int DM_W      = PROD_W;
   localparam int CSR_W     = 17;
   localparam int THR_W     = CSR_W + FRAC_BITS;
   localparam int SQ_W      = 2 * MAG_W + 2;
   localparam int V_W       = SQ_W + FRAC_BITS - 1;
   localparam int CH_W      = (V_W + 2) / 3;
   localparam int PP_W      = CH_W + MAG_W;
   localparam int MY_W      = V_W + MAG_W;
   localparam int MX_W      = MAG_W + FRAC_BITS;
   localparam int NM_W      = MY_W + 1;
   localparam int GN_W      = NM_W + FRAC_BITS;
   localparam int GQ_W      = 33;
   localparam int HI_W      = GN_W - GQ_W;
   localparam int METRIC_W  = 31;
   localparam int LANE_LAT  = GQ_W + 5;

   localparam logic signed [DQ_W-1:0] ONE_Q   = DQ_W'(1) << FRAC_BITS;
   localparam logic [GQ_W-1:0]        LIM_POS = GQ_W'(32'h7FFF_FFFF);
   localparam logic [GQ_W-1:0]        LIM_NEG = GQ_W'(33'h0_8000_0000);
   localparam logic [METRIC_W-1:0]    METRIC_MAX = '1;

   typedef struct packed {
      logic signed [ENT_W-1:0] t_00;
      logic signed [ENT_W-1:0] t_01;
      logic signed [ENT_W-1:0] t_10;
      logic signed [ENT_W-1:0] t_11;
   } req_type;

   typedef struct packed {
      logic [METRIC_W-1:0]     metric_value;
      logic signed [ENT_W-1:0] grad_00;
      logic signed [ENT_W-1:0] grad_01;
      logic signed [ENT_W-1:0] grad_10;
      logic signed [ENT_W-1:0] grad_11;
      logic                    valid_res;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] x_mag;
      logic             x_neg;
      logic [MAG_W-1:0] a_mag;
      logic             a_pos;
   } lane_type;

   typedef struct packed {
      logic [DM_W-1:0]   dm;
      logic              pass;
      logic [SQ_W-1:0]   sq_sum;
      lane_type [3:0]    lane;
   } front_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [DQ_W-1:0] x);
      logic [DQ_W-1:0] m;
      m = x[DQ_W-1] ? DQ_W'(-x) : DQ_W'(x);
      return m[MAG_W-1:0];
   endfunction

endpackage

// ===== design/shape_size_orient_barrier_2x2.sv =====
// Top level: barrier test, metric value and gradient of a 2x2 matrix, fully pipelined.
// One item is taken on every cycle that start is high; busy is always low. Each item gives
// exactly one result, strobed on rsp_strobe after it has passed 2 front stages, the 82-stage
// value divider (a load stage, then one quotient bit a stage), 38 gradient lane stages with
// their 33-step dividers, and the output register. Results cannot be held off by the receiver.
// csr_write_data sets the barrier threshold; write it only while no item is in flight.
module shape_size_orient_barrier_2x2 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ssob_pkg::req_type             req_item,
   input  logic                          csr_write_enable,
   input  logic [ssob_pkg::CSR_W-1:0]    csr_write_data,
   output logic                          rsp_strobe,
   output ssob_pkg::rsp_type             rsp_item
);
   import ssob_pkg::*;

   typedef struct packed {
      logic [METRIC_W-1:0] metric;
      logic                vsat;
      logic                pass;
   } side_type;

   logic [CSR_W-1:0] csr_ff;
   logic             f_vld;
   front_type        f_data;
   logic             v_vld;
   logic [V_W-1:0]   v_q;
   front_type        v_data;

   logic [ENT_W-1:0] grad [0:3];
   logic [3:0]       gsat;

   side_type         side_in;
   side_type         side_ff [1:LANE_LAT];
   logic [LANE_LAT:1] vld_ff;

   rsp_type          rsp_in;
   rsp_type          rsp_ff;
   logic             strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write_enable) begin
         csr_ff <= csr_write_data;
      end
   end

   ssob_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (start),
      .in_item  (req_item),
      .thr      (THR_W'(csr_ff) << FRAC_BITS),
      .out_vld  (f_vld),
      .out_data (f_data)
   );

   ssob_vdiv u_vdiv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (f_vld),
      .in_data  (f_data),
      .out_vld  (v_vld),
      .out_v    (v_q),
      .out_data (v_data)
   );

   for (genvar j = 0; j < 4; j++) begin : g_lane
      ssob_glane u_lane (
         .clock (clock),
         .v     (v_q),
         .lane  (v_data.lane[j]),
         .dm    (v_data.dm),
         .grad  (grad[j]),
         .sat   (gsat[j])
      );
   end

   always_comb begin
      side_in.vsat   = |v_q[V_W-1:METRIC_W];
      side_in.metric = side_in.vsat ? METRIC_MAX : v_q[METRIC_W-1:0];
      side_in.pass   = v_data.pass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[LANE_LAT-1:1], v_vld};
         strobe_ff <= vld_ff[LANE_LAT];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[1] <= side_in;
      for (int k = 2; k <= LANE_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_comb begin
      rsp_in = '0;
      if (side_ff[LANE_LAT].pass) begin
         rsp_in.metric_value = side_ff[LANE_LAT].metric;
         rsp_in.grad_00      = grad[0];
         rsp_in.grad_01      = grad[1];
         rsp_in.grad_10      = grad[2];
         rsp_in.grad_11      = grad[3];
         rsp_in.valid_res    = 1'b1;
         rsp_in.saturated    = side_ff[LANE_LAT].vsat | (|gsat);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== design/ssob_front.sv =====
// Front end: determinant, barrier test, squared distance sum and per-entry operands.
module ssob_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   input  ssob_pkg::req_type            in_item,
   input  logic [ssob_pkg::THR_W-1:0]   thr,
   output logic                         out_vld,
   output ssob_pkg::front_type          out_data
);
   import ssob_pkg::*;

   logic signed [ENT_W-1:0] t00, t01, t10, t11;
   logic signed [DQ_W-1:0]  dq0, dq3;
   logic signed [PROD_W-1:0] p1_in, p2_in;
   lane_type [3:0]          lane_in;
   logic [PROD_W-1:0]       sq_in [0:3];

   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   logic [PROD_W-1:0]       sq_ff [0:3];
   lane_type [3:0]          lane_ff;
   logic                    vld_a_ff;

   logic signed [PROD_W:0]  diff;
   logic                    pos;
   front_type               data_in;
   front_type               data_ff;
   logic                    vld_b_ff;

   assign t00 = in_item.t_00;
   assign t01 = in_item.t_01;
   assign t10 = in_item.t_10;
   assign t11 = in_item.t_11;
   assign dq0 = {t00[ENT_W-1], t00} - ONE_Q;
   assign dq3 = {t11[ENT_W-1], t11} - ONE_Q;
   assign p1_in = t00 * t11;
   assign p2_in = t01 * t10;

   always_comb begin
      lane_in[0].x_mag = mag_of(dq0);
      lane_in[0].x_neg = dq0[DQ_W-1];
      lane_in[0].a_mag = mag_of({t11[ENT_W-1], t11});
      lane_in[0].a_pos = !t11[ENT_W-1] && (|t11);
      lane_in[1].x_mag = mag_of({t01[ENT_W-1], t01});
      lane_in[1].x_neg = t01[ENT_W-1];
      lane_in[1].a_mag = mag_of({t10[ENT_W-1], t10});
      lane_in[1].a_pos = t10[ENT_W-1];
      lane_in[2].x_mag = mag_of({t10[ENT_W-1], t10});
      lane_in[2].x_neg = t10[ENT_W-1];
      lane_in[2].a_mag = mag_of({t01[ENT_W-1], t01});
      lane_in[2].a_pos = t01[ENT_W-1];
      lane_in[3].x_mag = mag_of(dq3);
      lane_in[3].x_neg = dq3[DQ_W-1];
      lane_in[3].a_mag = mag_of({t00[ENT_W-1], t00});
      lane_in[3].a_pos = !t00[ENT_W-1] && (|t00);
      for (int j = 0; j < 4; j++) begin
         sq_in[j] = PROD_W'(lane_in[j].x_mag) * PROD_W'(lane_in[j].x_mag);
      end
   end

   always_comb begin
      diff            = {p1_ff[PROD_W-1], p1_ff} - {p2_ff[PROD_W-1], p2_ff};
      pos             = p1_ff > p2_ff;
      data_in.dm      = diff[DM_W-1:0];
      data_in.pass    = pos && (diff[DM_W-1:0] > DM_W'(thr));
      data_in.sq_sum  = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]) + SQ_W'(sq_ff[3]);
      data_in.lane    = lane_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_vld;
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      sq_ff   <= sq_in;
      lane_ff <= lane_in;
      data_ff <= data_in;
   end

   assign out_vld  = vld_b_ff;
   assign out_data = data_ff;

endmodule

// ===== design/ssob_vdiv.sv =====
// Pipelined restoring divider for the metric value, one quotient bit per stage.
module ssob_vdiv (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  ssob_pkg::front_type         in_data,
   output logic                        out_vld,
   output logic [ssob_pkg::V_W-1:0]    out_v,
   output ssob_pkg::front_type         out_data
);
   import ssob_pkg::*;

   logic [DM_W-1:0] rem_ff  [0:V_W];
   logic [V_W-1:0]  quo_ff  [0:V_W];
   logic [V_W-1:0]  num_ff  [0:V_W];
   front_type       side_ff [0:V_W];
   logic [V_W:0]    vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[V_W-1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      quo_ff[0]  <= '0;
      num_ff[0]  <= V_W'(in_data.sq_sum) << (FRAC_BITS - 1);
      side_ff[0] <= in_data;
   end

   for (genvar k = 1; k <= V_W; k++) begin : g_step
      logic [DM_W:0]  trial, diff;
      logic           ge;
      logic [V_W-1:0] quo_in;
      always_comb begin
         trial          = {rem_ff[k-1], num_ff[k-1][V_W-k]};
         diff           = trial - {1'b0, side_ff[k-1].dm};
         ge             = trial >= {1'b0, side_ff[k-1].dm};
         quo_in         = quo_ff[k-1];
         quo_in[V_W-k]  = ge;
      end
      always_ff @(posedge clock) begin
         rem_ff[k]  <= ge ? diff[DM_W-1:0] : trial[DM_W-1:0];
         quo_ff[k]  <= quo_in;
         num_ff[k]  <= num_ff[k-1];
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_vld  = vld_ff[V_W];
   assign out_v    = quo_ff[V_W];
   assign out_data = side_ff[V_W];

endmodule

// ===== design/ssob_glane.sv =====
// One gradient entry: v times adjugate term, combine with D, divide by det, saturate.
module ssob_glane (
   input  logic                         clock,
   input  logic [ssob_pkg::V_W-1:0]     v,
   input  ssob_pkg::lane_type           lane,
   input  logic [ssob_pkg::DM_W-1:0]    dm,
   output logic [ssob_pkg::ENT_W-1:0]   grad,
   output logic                         sat
);
   import ssob_pkg::*;

   logic [3*CH_W-1:0] vp;
   logic [PP_W-1:0]   pp_ff [0:2];
   lane_type          l1_ff;
   logic [DM_W-1:0]   dm1_ff, dm2_ff, dm3_ff;

   logic [MY_W-1:0]   my2_ff;
   logic [MX_W-1:0]   mx2_ff;
   logic              xneg2_ff, ypos2_ff;

   logic [NM_W-1:0]   myw, mxw, nm_in;
   logic              same, my_ge, neg_in;
   logic [NM_W-1:0]   nm3_ff;
   logic              neg3_ff;

   logic [GN_W-1:0]   nshift;
   logic [HI_W-1:0]   hi;

   logic [DM_W-1:0]   rem_ff [0:GQ_W];
   logic [GQ_W-1:0]   quo_ff [0:GQ_W];
   logic [GQ_W-1:0]   num_ff [0:GQ_W];
   logic [DM_W-1:0]   den_ff [0:GQ_W];
   logic              ovf_ff [0:GQ_W];
   logic              neg_ff [0:GQ_W];

   logic [GQ_W-1:0]   lim, gmag, gval;
   logic              sat_in;
   logic [ENT_W-1:0]  grad_ff;
   logic              sat_ff;

   assign vp = (3*CH_W)'(v);

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         pp_ff[j] <= PP_W'(vp[j*CH_W +: CH_W]) * PP_W'(lane.a_mag);
      end
      l1_ff  <= lane;
      dm1_ff <= dm;
   end

   always_ff @(posedge clock) begin
      my2_ff   <= MY_W'(pp_ff[0]) + (MY_W'(pp_ff[1]) << CH_W) + (MY_W'(pp_ff[2]) << (2*CH_W));
      mx2_ff   <= MX_W'(l1_ff.x_mag) << FRAC_BITS;
      xneg2_ff <= l1_ff.x_neg;
      ypos2_ff <= l1_ff.a_pos;
      dm2_ff   <= dm1_ff;
   end

   always_comb begin
      myw   = NM_W'(my2_ff);
      mxw   = NM_W'(mx2_ff);
      same  = xneg2_ff == ypos2_ff;
      my_ge = myw >= mxw;
      if (same) begin
         nm_in  = myw + mxw;
         neg_in = xneg2_ff;
      end else if (my_ge) begin
         nm_in  = myw - mxw;
         neg_in = ypos2_ff;
      end else begin
         nm_in  = mxw - myw;
         neg_in = xneg2_ff;
      end
   end

   always_ff @(posedge clock) begin
      nm3_ff  <= nm_in;
      neg3_ff <= neg_in;
      dm3_ff  <= dm2_ff;
   end

   assign nshift = GN_W'(nm3_ff) << FRAC_BITS;
   assign hi     = nshift[GN_W-1:GQ_W];

   always_ff @(posedge clock) begin
      rem_ff[0] <= hi[DM_W-1:0];
      quo_ff[0] <= '0;
      num_ff[0] <= nshift[GQ_W-1:0];
      den_ff[0] <= dm3_ff;
      ovf_ff[0] <= hi >= HI_W'(dm3_ff);
      neg_ff[0] <= neg3_ff;
   end

   for (genvar k = 1; k <= GQ_W; k++) begin : g_step
      logic [DM_W:0]   trial, diff;
      logic            ge;
      logic [GQ_W-1:0] quo_in;
      always_comb begin
         trial          = {rem_ff[k-1], num_ff[k-1][GQ_W-k]};
         diff           = trial - {1'b0, den_ff[k-1]};
         ge             = trial >= {1'b0, den_ff[k-1]};
         quo_in         = quo_ff[k-1];
         quo_in[GQ_W-k] = ge;
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? diff[DM_W-1:0] : trial[DM_W-1:0];
         quo_ff[k] <= quo_in;
         num_ff[k] <= num_ff[k-1];
         den_ff[k] <= den_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   always_comb begin
      lim    = neg_ff[GQ_W] ? LIM_NEG : LIM_POS;
      sat_in = ovf_ff[GQ_W] || (quo_ff[GQ_W] > lim);
      gmag   = sat_in ? lim : quo_ff[GQ_W];
      gval   = neg_ff[GQ_W] ? GQ_W'(-gmag) : gmag;
   end

   always_ff @(posedge clock) begin
      grad_ff <= gval[ENT_W-1:0];
      sat_ff  <= sat_in;
   end

   assign grad = grad_ff;
   assign sat  = sat_ff;

endmodule
